[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WordWidth  = 32;
   localparam int HashWords  = 8;
   localparam int BlockWords = 16;
   localparam int Rounds     = 64;
   localparam int CountWidth = 61;
   localparam int PadLimit   = 55;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [HashWords-1:0] hash_type;

   localparam hash_type InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   // Control from sequencer to round unit
   typedef struct packed {
      logic start;   // load working vars from chain, clear round count
      logic init;    // reload chain with initial values
   } core_ctl_type;

endpackage

[design/sha256_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One round per cycle over a 16-word rolling schedule, then chain update.
// ----------------------------------------------------------------------------
module sha256_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha256_pkg::core_ctl_type ctl,
   input  sha256_pkg::word_type  block [sha256_pkg::BlockWords],
   output logic                  busy,
   output sha256_pkg::hash_type  chain
);
   import sha256_pkg::*;

   word_type w_ff [BlockWords];
   word_type w_in [BlockWords];
   hash_type v_ff, v_in, chain_ff, chain_in;
   logic [5:0] rnd_ff, rnd_in;
   logic busy_ff, busy_in, fin_ff, fin_in;
   word_type t1, t2, s0, s1, wnew;

   always_comb begin
      s0   = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_in = w_ff; v_in = v_ff; chain_in = chain_ff;
      rnd_in = rnd_ff; busy_in = busy_ff; fin_in = 1'b0;
      if (ctl.start) begin
         w_in = block; v_in = chain_ff; rnd_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < BlockWords - 1; i++) w_in[i] = w_ff[i+1];
         w_in[BlockWords-1] = wnew;
         v_in = {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'(Rounds - 1)) begin
            busy_in = 1'b0; fin_in = 1'b1;
         end
      end
      if (fin_ff)
         for (int i = 0; i < HashWords; i++) chain_in[i] = chain_ff[i] + v_ff[i];
      if (ctl.init) chain_in = InitHash;
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in; v_ff <= v_in; chain_ff <= chain_in; rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0; fin_ff <= 1'b0; chain_ff <= InitHash;
      end else begin
         busy_ff <= busy_in; fin_ff <= fin_in;
      end
   end

   assign busy  = busy_ff | fin_ff;
   assign chain = chain_ff;

   a_fin_after_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !ctl.start && rnd_ff == 6'(Rounds - 1) |=> fin_ff)
      else $error("chain update missed");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !busy_ff) else $error("round run overlaps chain update");
   a_rnd_start: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff && rnd_ff == '0) else $error("bad round start");
endmodule

[design/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Absorbs a byte stream, pads it and emits the 256-bit digest as 8 words.
// ----------------------------------------------------------------------------
// channel | dir | tdata                     | tuser       | tlast
// req     | in  | [7:0] data_byte           | byte_valid  | message_end
// rsp     | out | [31:0] digest_word        | word_index  | final_word
//
// While idle, bytes are accepted; the 64th byte of a block starts 64 rounds in the
// shared round unit, followed by a chain update.
// A closing item adds the pad fill, one or two block runs and 8 output words.
// req_tready is low while a block runs, the pad fill is written or the digest is being sent.
// rsp stalls simply hold the current word. Reset is synchronous; no sweep.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // final_word
);
   import sha256_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0; // taking bytes
   localparam logic [2:0] S_RUN  = 3'd1; // message block compressing
   localparam logic [2:0] S_PAD  = 3'd2; // writing pad fill, one word a cycle
   localparam logic [2:0] S_P1   = 3'd3; // first padding block compressing
   localparam logic [2:0] S_P2   = 3'd4; // final block compressing
   localparam logic [2:0] S_OUT  = 3'd5; // sending digest

   logic [2:0] state_ff, state_in;
   word_type buf_ff [BlockWords];
   word_type buf_in [BlockWords];
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [4:0] pw_ff, pw_in;      // pad word pointer, counts to 16
   logic two_ff, two_in;          // length does not fit: two pad blocks
   logic [2:0] oi_ff, oi_in;
   logic wait_ff, wait_in;        // start pulse sent, wait for busy
   logic req_tlast_ff;            // end mark seen together with the block-closing byte
   core_ctl_type ctl;
   logic busy;
   hash_type chain;
   logic acc, outacc;
   logic [5:0] pos;
   logic [63:0] bits;

   assign acc    = req_tvalid && req_tready;
   assign outacc = rsp_tvalid && rsp_tready;
   assign pos    = cnt_ff[5:0];
   assign bits   = {cnt_ff, 3'b000};

   always_comb begin
      state_in = state_ff; buf_in = buf_ff; cnt_in = cnt_ff; pw_in = pw_ff;
      two_in = two_ff; oi_in = oi_ff; wait_in = 1'b0;
      ctl = '0;
      case (state_ff)
         S_IDLE: if (acc) begin
            if (req_tuser) begin
               buf_in[pos[5:2]][8*(3-pos[1:0]) +: 8] = req_tdata;
               cnt_in = cnt_ff + 1'b1;
            end
            if (req_tuser && pos == 6'd63) begin
               ctl.start = 1'b1; wait_in = 1'b1; state_in = S_RUN;
            end else if (req_tlast) begin
               // append marker; the fill sweep zeroes the rest
               buf_in[cnt_in[5:2]][8*(3-cnt_in[1:0]) +: 8] = 8'h80;
               for (int b = 0; b < 3; b++)
                  if (b >= 32'(cnt_in[1:0]))
                     buf_in[cnt_in[5:2]][8*(2-b) +: 8] = 8'h00;
               pw_in = {1'b0, cnt_in[5:2]} + 5'd1;
               two_in = cnt_in[5:0] > 6'(PadLimit);
               state_in = S_PAD;
            end
         end
         S_RUN: if (!wait_ff && !busy) begin
            if (req_tlast_ff) begin
               buf_in[0] = 32'h80000000;
               pw_in = 5'd1; two_in = 1'b0; state_in = S_PAD;
            end else state_in = S_IDLE;
         end
         S_PAD: begin
            if (pw_ff < 5'(BlockWords)) begin
               buf_in[pw_ff[3:0]] = '0; pw_in = pw_ff + 5'd1;
            end else begin
               if (!two_ff) begin
                  buf_in[14] = bits[63:32]; buf_in[15] = bits[31:0];
               end
               ctl.start = 1'b1; wait_in = 1'b1;
               state_in = two_ff ? S_P1 : S_P2;
            end
         end
         S_P1: if (!wait_ff && !busy) begin
            for (int i = 0; i < BlockWords; i++) buf_in[i] = '0;
            buf_in[14] = bits[63:32]; buf_in[15] = bits[31:0];
            ctl.start = 1'b1; wait_in = 1'b1; state_in = S_P2;
         end
         S_P2: if (!wait_ff && !busy) begin
            oi_in = '0; state_in = S_OUT;
         end
         S_OUT: if (outacc) begin
            oi_in = oi_ff + 3'd1;
            if (oi_ff == 3'(HashWords - 1)) begin
               ctl.init = 1'b1; cnt_in = '0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in; pw_ff <= pw_in; two_ff <= two_in; oi_ff <= oi_in;
      if (state_ff == S_IDLE && acc) req_tlast_ff <= req_tlast;
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; wait_ff <= wait_in;
      end
   end

   sha256_core u_core (
      .clock (clock), .reset (reset), .ctl (ctl), .block (buf_in),
      .busy (busy), .chain (chain));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = chain[oi_ff];
   assign rsp_tuser  = oi_ff;
   assign rsp_tlast  = (oi_ff == 3'(HashWords - 1));

   a_out_only_idle_in: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken during digest");
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      outacc && rsp_tlast |=> cnt_ff == '0) else $error("count not cleared");
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy) else $error("round unit did not start");
endmodule
